// ===== sv/chunked_slot_allocator_top_assert.svh =====
`ifndef CHUNKED_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define CHUNKED_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CSA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csa assertion failed");

// next-cycle implication, checked outside reset
`define CSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csa assertion failed");

`endif

// ===== sv/csa_pkg.sv =====
package csa_pkg;

   // operation codes
   localparam logic [1:0] FUNC_ALLOC  = 2'd0;
   localparam logic [1:0] FUNC_PLACE  = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;
   // unassigned operation code, always rejected
   localparam logic [1:0] FUNC_NONE   = 2'd3;

   // result status codes
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_BAD  = 2'd2;

   // slots per chunk after reset
   localparam logic [8:0] CAP_RESET = 9'd64;

   // request transaction
   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] entity_id;
      logic [3:0]  chunk_index;
      logic [7:0]  slot_index;
   } csa_req_type;

   // response transaction
   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  given_chunk;
      logic [7:0]  given_slot;
      logic        moved;
      logic [31:0] moved_entity;
      logic [7:0]  moved_to_slot;
   } csa_rsp_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MOVE
   } csa_state_type;

endpackage

// ===== sv/chunked_slot_allocator_top.sv =====
// Chunked slot allocator: packed slots over a bounded set of chunks.
// Request channel (req_valid / req_stall / req_data): allocate, place owner
// or remove, one transaction at a time. Response channel (rsp_valid /
// rsp_stall / rsp_data): exactly one response per request, in order.
// csr_write_en / csr_write_data set slots per chunk; write it only while idle.
// The response is loaded into the output register from the execute step, or
// from the move step for a remove that moves the last entity into the hole.
// A moving remove passes through the extra move step, which covers the
// registered read of the owner memory before its write-back.
// The request side takes a new transaction while an earlier response still
// waits in the output register.
// Reset: chunk 0 open, all slot counts zero, 64 slots per chunk. The owner
// memory is not swept; every slot is written with zero when allocated.
// When rsp_stall is high the response holds; the next transaction is taken
// and waits in its execute or move step until the output register frees up.
module chunked_slot_allocator_top #(
   parameter int MAX_CHUNKS     = 16,
   parameter int SLOTS_MAX      = 256,
   parameter int ENTITY_ID_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  csa_pkg::csa_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output csa_pkg::csa_rsp_type rsp_data,
   input  logic                 csr_write_en,
   input  logic [8:0]           csr_write_data
);

   `include "chunked_slot_allocator_top_assert.svh"

   localparam int ID_W      = (ENTITY_ID_BITS < 32) ? ENTITY_ID_BITS : 32;
   localparam int CAP_MAX   = (SLOTS_MAX < 511) ? SLOTS_MAX : 511;
   localparam int CNT_W     = $clog2(CAP_MAX + 1);
   localparam int SLOT_W    = (CAP_MAX > 1) ? $clog2(CAP_MAX) : 1;
   localparam int CH_W      = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int OPEN_W    = $clog2(MAX_CHUNKS + 1);
   localparam int ADDR_W    = CH_W + SLOT_W;
   localparam int MEM_DEPTH = MAX_CHUNKS * (2 ** SLOT_W);

   // state registers
   csa_pkg::csa_state_type state_ff, state_in;
   csa_pkg::csa_req_type   req_ff, req_in;
   csa_pkg::csa_rsp_type   rsp_data_ff, rsp_data_in, rsp_new;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [8:0]             csr_ff, csr_in;
   logic [OPEN_W-1:0]      open_ff, open_in;
   logic [CNT_W-1:0]       used_count_ff [MAX_CHUNKS];
   logic [CNT_W-1:0]       used_count_in [MAX_CHUNKS];
   logic [MAX_CHUNKS-1:0]  room_ff, room_in;

   // owner memory
   logic [ID_W-1:0]   owner_mem [MEM_DEPTH];
   logic [ID_W-1:0]   rd_data_ff;
   logic              owner_we, owner_re;
   logic [ADDR_W-1:0] owner_wa, owner_ra;
   logic [ID_W-1:0]   owner_wd;

   // datapath controls
   logic              accept, rsp_free, rsp_load, open_inc;
   logic              cnt_we;
   logic [CH_W-1:0]   cnt_wa;
   logic [CNT_W-1:0]  cnt_wd;
   logic [8:0]        cap_ff, cap_in;
   logic [CH_W-1:0]   ch_idx, first_idx, alloc_idx, sel_idx;
   logic [CNT_W-1:0]  sel_cnt, last_cnt;
   logic [SLOT_W-1:0] sl_addr;
   logic              ch_ok, has_room, can_open, alloc_ok;
   logic              place_ok, remove_ok, need_move;

   // handshakes
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != csa_pkg::ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // capacity clamp of the register value
   function automatic logic [8:0] clamp_cap(input logic [8:0] raw);
      logic [8:0] c;
      c = raw;
      if (raw == 9'd0) begin
         c = 9'd1;
      end else if (16'(raw) > 16'(SLOTS_MAX)) begin
         c = 9'(SLOTS_MAX);
      end
      return c;
   endfunction

   assign csr_in = csr_write_en ? csr_write_data : csr_ff;
   assign cap_ff = clamp_cap(csr_ff);
   assign cap_in = clamp_cap(csr_in);
   assign req_in = accept ? req_data : req_ff;

   // request decode
   always_comb begin
      ch_idx    = CH_W'(req_ff.chunk_index);
      sl_addr   = SLOT_W'(req_ff.slot_index);
      ch_ok     = 16'(req_ff.chunk_index) < 16'(open_ff);
      has_room  = |room_ff;
      can_open  = 16'(open_ff) < 16'(MAX_CHUNKS);
      alloc_ok  = has_room || can_open;
      first_idx = '0;
      for (int i = MAX_CHUNKS - 1; i >= 0; i--) begin
         if (room_ff[i]) begin
            first_idx = CH_W'(i);
         end
      end
      alloc_idx = has_room ? first_idx : CH_W'(open_ff);
      sel_idx   = (req_ff.func == csa_pkg::FUNC_ALLOC) ? alloc_idx : ch_idx;
      sel_cnt   = used_count_ff[sel_idx];
      last_cnt  = sel_cnt - CNT_W'(1);
      place_ok  = ch_ok && (16'(req_ff.slot_index) < 16'(sel_cnt));
      remove_ok = ch_ok && (sel_cnt != '0) && (16'(req_ff.slot_index) < 16'(sel_cnt));
      need_move = (req_ff.func == csa_pkg::FUNC_REMOVE) && remove_ok
                  && (16'(req_ff.slot_index) != 16'(last_cnt));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csa_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = csa_pkg::ST_EXEC;
            end
         end
         csa_pkg::ST_EXEC: begin
            if (need_move) begin
               state_in = csa_pkg::ST_MOVE;
            end else if (rsp_free) begin
               state_in = csa_pkg::ST_IDLE;
            end
         end
         csa_pkg::ST_MOVE: begin
            if (rsp_free) begin
               state_in = csa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = csa_pkg::ST_IDLE;
         end
      endcase
   end

   // per-state controls and response build
   always_comb begin
      rsp_load = 1'b0;
      open_inc = 1'b0;
      cnt_we   = 1'b0;
      cnt_wa   = sel_idx;
      cnt_wd   = sel_cnt;
      owner_we = 1'b0;
      owner_wa = {ch_idx, sl_addr};
      owner_wd = ID_W'(req_ff.entity_id);
      owner_re = 1'b0;
      owner_ra = {ch_idx, SLOT_W'(last_cnt)};
      rsp_new  = '0;
      unique case (state_ff)
         csa_pkg::ST_EXEC: begin
            if (need_move) begin
               // fetch the owner of the last slot, commit the count now
               owner_re = 1'b1;
               cnt_we   = 1'b1;
               cnt_wd   = last_cnt;
            end else if (rsp_free) begin
               rsp_load       = 1'b1;
               rsp_new.status = csa_pkg::STAT_BAD;
               unique case (req_ff.func)
                  csa_pkg::FUNC_ALLOC: begin
                     if (alloc_ok) begin
                        rsp_new.status      = csa_pkg::STAT_OK;
                        rsp_new.given_chunk = 4'(sel_idx);
                        rsp_new.given_slot  = 8'(sel_cnt);
                        open_inc = !has_room;
                        cnt_we   = 1'b1;
                        cnt_wd   = sel_cnt + CNT_W'(1);
                        // fresh slot starts with no owner
                        owner_we = 1'b1;
                        owner_wa = {sel_idx, SLOT_W'(sel_cnt)};
                        owner_wd = '0;
                     end else begin
                        rsp_new.status = csa_pkg::STAT_FULL;
                     end
                  end
                  csa_pkg::FUNC_PLACE: begin
                     if (place_ok) begin
                        rsp_new.status = csa_pkg::STAT_OK;
                        owner_we       = 1'b1;
                     end
                  end
                  csa_pkg::FUNC_REMOVE: begin
                     // removing the last slot moves nothing
                     if (remove_ok) begin
                        rsp_new.status = csa_pkg::STAT_OK;
                        cnt_we = 1'b1;
                        cnt_wd = last_cnt;
                     end
                  end
                  default: begin
                     rsp_new.status = csa_pkg::STAT_BAD;
                  end
               endcase
            end
         end
         csa_pkg::ST_MOVE: begin
            // write the moved owner into the hole
            if (rsp_free) begin
               rsp_load              = 1'b1;
               owner_we              = 1'b1;
               owner_wd              = rd_data_ff;
               rsp_new.status        = csa_pkg::STAT_OK;
               rsp_new.moved         = 1'b1;
               rsp_new.moved_entity  = 32'(rd_data_ff);
               rsp_new.moved_to_slot = req_ff.slot_index;
            end
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   // output register
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = rsp_load ? rsp_new : rsp_data_ff;

   // chunk counts, open count and room flags
   assign open_in = open_inc ? open_ff + OPEN_W'(1) : open_ff;

   always_comb begin
      for (int i = 0; i < MAX_CHUNKS; i++) begin
         used_count_in[i] = used_count_ff[i];
      end
      if (cnt_we) begin
         used_count_in[cnt_wa] = cnt_wd;
      end
      for (int i = 0; i < MAX_CHUNKS; i++) begin
         room_in[i] = (i < int'(open_in)) && (16'(used_count_in[i]) < 16'(cap_in));
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         csr_ff       <= csa_pkg::CAP_RESET;
         open_ff      <= OPEN_W'(1);
         room_ff      <= MAX_CHUNKS'(1);
         for (int i = 0; i < MAX_CHUNKS; i++) begin
            used_count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         csr_ff       <= csr_in;
         open_ff      <= open_in;
         room_ff      <= room_in;
         for (int i = 0; i < MAX_CHUNKS; i++) begin
            used_count_ff[i] <= used_count_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   // owner memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (owner_we) begin
         owner_mem[owner_wa] <= owner_wd;
      end
      if (owner_re) begin
         rd_data_ff <= owner_mem[owner_ra];
      end
   end

   // checks
   `CSA_ASSERT_NEXT(a_accept_exec, clock, reset, accept, state_ff == csa_pkg::ST_EXEC)
   `CSA_ASSERT_IMPLY(a_move_is_remove, clock, reset, state_ff == csa_pkg::ST_MOVE, req_ff.func == csa_pkg::FUNC_REMOVE)
   `CSA_ASSERT_IMPLY(a_write_with_rsp, clock, reset, owner_we, rsp_load)
   `CSA_ASSERT_IMPLY(a_slot_in_cap, clock, reset, rsp_load && rsp_new.status == csa_pkg::STAT_OK && req_ff.func == csa_pkg::FUNC_ALLOC, 16'(sel_cnt) < 16'(cap_ff))

endmodule
